// File: rtl/cfba_pkg.sv
// Shared constants, codes and types for the contiguous frame bitmap allocator.
`default_nettype none

package cfba_pkg;

  // Geometry of the frame map
  localparam int NUM_FRAMES = 16384;
  localparam int DMA_LIMIT  = 4096;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 32;

  localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
  localparam int DMA_WORDS  = DMA_LIMIT / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 26;
  localparam int COUNT_W  = 15;
  localparam int LEN_W    = 27;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 10;
  localparam int RCNT_W   = LEN_W - PAGE_SHIFT + 1;  // rounded-up frame count
  localparam int REND_W   = RCNT_W + 1;              // first + count - 1

  // Stream packing
  localparam int IN_BASE_LO  = 0;
  localparam int IN_COUNT_LO = IN_BASE_LO + ADDR_W;
  localparam int IN_LEN_LO   = IN_COUNT_LO + COUNT_W;
  localparam int IN_DATA_W   = ((IN_LEN_LO + LEN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((ADDR_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] ACTIVE_WORDS_RST = CFG_W'(MAP_WORDS);

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_DMA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } fsm_state_t;

  // One map word evaluated against the pending run
  typedef struct packed {
    logic               hit;
    logic [BIT_W-1:0]   pos;
    logic [COUNT_W-1:0] run_out;
  } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/contiguous_frame_bitmap_allocator.sv
// Top level: command sequencer around the frame map memory and word scanner.
//
//   channel  | ports                          | contents
//   ---------+--------------------------------+-------------------------------------
//   in       | in_tvalid/in_tready/tdata/tuser| command, base, frame count, length
//   out      | out_tvalid/out_tready/tdata/tuser | result address, status
//   cfg      | cfg_valid/cfg_ready/cfg_data   | active_words
//
// Map access is read-modify-write through the map memory's read port and write port.
// Allocate: scans map words (up to 512 words), then marks each word of the run found.
// Free/reserve: reads and writes back each word touched; zero-length commands mark nothing.
// After reset a clearing pass sets all 512 map words used (in_tready low).
// A finished result waits in the output register; the next command is taken meanwhile.
`default_nettype none

module contiguous_frame_bitmap_allocator
  import cfba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // base_address, frames, byte_length, pad
  input  wire logic [CMD_W-1:0]      in_tuser,   // cmd
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // result_address, pad
  output logic [STATUS_W-1:0]        out_tuser,  // status
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data    // active_words
);

  fsm_state_t state_r, state_nxt;

  logic [WORD_AW-1:0]  mw_r, mw_nxt;
  logic [WORD_AW-1:0]  scan_w_r, scan_w_nxt;
  logic [WORD_AW-1:0]  scan_end_r, scan_end_nxt;
  logic                pass_r, pass_nxt;         // 1: below-DMA pass
  logic [COUNT_W-1:0]  run_r, run_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [FRAME_W-1:0]  lo_r, lo_nxt;
  logic [FRAME_W-1:0]  hi_r, hi_nxt;
  logic                set_r, set_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CFG_W-1:0]    active_words_r, active_words_nxt;

  logic                 ram_we;
  logic [WORD_AW-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  scan_res_t            scan;

  // Active range
  logic [CFG_W-1:0]      limit_words;
  logic [CFG_W-1:0]      dma_words;
  logic [FRAME_W:0]      limit_frames;

  // Free / reserve range setup
  logic [FRAME_W-1:0]    rng_first;
  logic [RCNT_W-1:0]     rng_cnt;
  logic [REND_W-1:0]     rng_end;
  logic                  rng_valid;
  logic [FRAME_W-1:0]    rng_hi;

  // Allocation hit
  logic [FRAME_W-1:0]    hit_end;
  logic [FRAME_W-1:0]    hit_first;

  logic [WORD_BITS-1:0]  mark_mask;

  assign limit_words  = (active_words_r > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS)
                                                              : active_words_r;
  assign dma_words    = (limit_words < CFG_W'(DMA_WORDS)) ? limit_words : CFG_W'(DMA_WORDS);
  assign limit_frames = (FRAME_W+1)'({limit_words, BIT_W'(0)});

  assign rng_first = base_r[ADDR_W-1:PAGE_SHIFT];
  assign rng_cnt   = (cmd_r == CMD_RESERVE)
                   ? RCNT_W'(len_r[LEN_W-1:PAGE_SHIFT]) + RCNT_W'(|len_r[PAGE_SHIFT-1:0])
                   : RCNT_W'(count_r);
  assign rng_end   = REND_W'(rng_first) + REND_W'(rng_cnt) - REND_W'(1);
  assign rng_valid = (rng_cnt != '0) && ((FRAME_W+1)'(rng_first) < limit_frames);
  assign rng_hi    = (rng_end < REND_W'(limit_frames)) ? rng_end[FRAME_W-1:0]
                                                       : FRAME_W'(limit_frames - 1'b1);

  assign hit_end   = {scan_w_r, scan.pos};
  assign hit_first = FRAME_W'((COUNT_W'(hit_end) + COUNT_W'(1)) - count_r);

  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      mark_mask[p] = ({mw_r, BIT_W'(p)} >= lo_r) && ({mw_r, BIT_W'(p)} <= hi_r);
    end
  end

  assign ram_raddr = (state_r == S_MARK_RD) ? mw_r : scan_w_r;

  cfba_map_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mw_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cfba_word_scan u_scan (
    .word_data (ram_rdata),
    .run_in    (run_r),
    .count     (count_r),
    .res       (scan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r           <= '0;
      out_valid_r    <= 1'b0;
      active_words_r <= ACTIVE_WORDS_RST;
    end else begin
      mw_r           <= mw_nxt;
      out_valid_r    <= out_valid_nxt;
      active_words_r <= active_words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_w_r     <= scan_w_nxt;
    scan_end_r   <= scan_end_nxt;
    pass_r       <= pass_nxt;
    run_r        <= run_nxt;
    cmd_r        <= cmd_nxt;
    base_r       <= base_nxt;
    count_r      <= count_nxt;
    len_r        <= len_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    set_r        <= set_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    mw_nxt           = mw_r;
    scan_w_nxt       = scan_w_r;
    scan_end_nxt     = scan_end_r;
    pass_nxt         = pass_r;
    run_nxt          = run_r;
    cmd_nxt          = cmd_r;
    base_nxt         = base_r;
    count_nxt        = count_r;
    len_nxt          = len_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    set_nxt          = set_r;
    res_addr_nxt     = res_addr_r;
    res_status_nxt   = res_status_r;
    out_valid_nxt    = out_valid_r;
    out_addr_nxt     = out_addr_r;
    out_status_nxt   = out_status_r;
    active_words_nxt = active_words_r;
    in_tready        = 1'b0;
    ram_we           = 1'b0;
    ram_wdata        = set_r ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);

    if (cfg_valid) begin
      active_words_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        mw_nxt    = mw_r + 1'b1;
        if (mw_r == WORD_AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          base_nxt  = in_tdata[IN_BASE_LO +: ADDR_W];
          count_nxt = in_tdata[IN_COUNT_LO +: COUNT_W];
          len_nxt   = in_tdata[IN_LEN_LO +: LEN_W];
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_addr_nxt   = '0;
        res_status_nxt = ST_DONE;
        run_nxt        = '0;
        state_nxt      = S_DONE;
        case (cmd_r) inside
          CMD_ALLOC, CMD_ALLOC_DMA: begin
            if (count_r == '0) begin
              res_status_nxt = ST_ZERO;
            end else if (cmd_r == CMD_ALLOC && limit_words > CFG_W'(DMA_WORDS)) begin
              scan_w_nxt   = WORD_AW'(DMA_WORDS);
              scan_end_nxt = WORD_AW'(limit_words - 1'b1);
              pass_nxt     = 1'b0;
              state_nxt    = S_SCAN_RD;
            end else if (dma_words != '0) begin
              scan_w_nxt   = '0;
              scan_end_nxt = WORD_AW'(dma_words - 1'b1);
              pass_nxt     = 1'b1;
              state_nxt    = S_SCAN_RD;
            end else begin
              res_status_nxt = ST_NO_RUN;
            end
          end
          default: begin
            if (rng_valid) begin
              lo_nxt    = rng_first;
              hi_nxt    = rng_hi;
              set_nxt   = (cmd_r == CMD_RESERVE);
              mw_nxt    = rng_first[FRAME_W-1:BIT_W];
              state_nxt = S_MARK_RD;
            end
          end
        endcase
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        if (scan.hit) begin
          lo_nxt       = hit_first;
          hi_nxt       = hit_end;
          set_nxt      = 1'b1;
          mw_nxt       = hit_first[FRAME_W-1:BIT_W];
          res_addr_nxt = ADDR_W'({hit_first, PAGE_SHIFT'(0)});
          state_nxt    = S_MARK_RD;
        end else if (scan_w_r == scan_end_r) begin
          // the upper pass falls back to the frames below the DMA limit
          if (!pass_r && dma_words != '0) begin
            scan_w_nxt   = '0;
            scan_end_nxt = WORD_AW'(dma_words - 1'b1);
            pass_nxt     = 1'b1;
            run_nxt      = '0;
            state_nxt    = S_SCAN_RD;
          end else begin
            res_status_nxt = ST_NO_RUN;
            state_nxt      = S_DONE;
          end
        end else begin
          scan_w_nxt = scan_w_r + 1'b1;
          run_nxt    = scan.run_out;
          state_nxt  = S_SCAN_RD;
        end
      end

      S_MARK_RD: begin
        state_nxt = S_MARK_WR;
      end

      S_MARK_WR: begin
        ram_we = 1'b1;
        if (mw_r == hi_r[FRAME_W-1:BIT_W]) begin
          state_nxt = S_DONE;
        end else begin
          mw_nxt    = mw_r + 1'b1;
          state_nxt = S_MARK_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_addr_r);
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// File: rtl/cfba_map_ram.sv
// Frame used-bit memory: one write port, one read port with registered data.
`default_nettype none

module cfba_map_ram
  import cfba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [WORD_AW-1:0]   waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic [WORD_AW-1:0]   raddr,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/cfba_word_scan.sv
// First-fit run search across one 32-frame map word, carrying the run length.
`default_nettype none

module cfba_word_scan
  import cfba_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word_data,  // 1 = frame used
  input  wire logic [COUNT_W-1:0]   run_in,
  input  wire logic [COUNT_W-1:0]   count,
  output scan_res_t                 res
);

  logic [COUNT_W-1:0]   run_end [WORD_BITS];
  logic [WORD_BITS-1:0] hit_vec;

  // run_end[p]: free frames ending at bit p; zero when bit p is used
  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      run_end[p] = run_in + COUNT_W'(p + 1);
      for (int j = 0; j <= p; j++) begin
        if (word_data[j]) begin
          run_end[p] = COUNT_W'(p - j);
        end
      end
      hit_vec[p] = (run_end[p] >= count);
    end
  end

  always_comb begin
    res.hit     = |hit_vec;
    res.pos     = '0;
    res.run_out = run_end[WORD_BITS-1];
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        res.pos = BIT_W'(p);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfba_checker.sv
// Port-level checks on the allocator, bound to the top level.
`default_nettype none

module cfba_checker
  import cfba_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [STATUS_W-1:0]   out_tuser
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // clearing pass follows reset: no command taken right after it
  assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("command taken during map clear");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_DONE || out_tuser == ST_NO_RUN || out_tuser == ST_ZERO)
    else $error("bad status code");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tdata == '0)
    else $error("failed transaction carries an address");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[PAGE_SHIFT-1:0] == '0)
    else $error("result address not frame aligned");

endmodule

bind contiguous_frame_bitmap_allocator cfba_checker u_cfba_checker (.*);

`default_nettype wire
